### src/ihpq_pkg.sv
// ----------------------------------------------------------------------------
// ihpq_pkg
// Shared constants, codes and types for the indexed heap priority queue.
// ----------------------------------------------------------------------------
package ihpq_pkg;

  localparam int unsigned CapacityDef  = 256;
  localparam int unsigned KeyWidthDef  = 32;
  localparam int unsigned HandleW      = 8;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned OpW          = 2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_DEAD = 2'd2,
    ST_RSVD = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_UP_RD,
    S_UP_CMP,
    S_RM_RD,
    S_RM_LAST,
    S_RM_WR,
    S_DN_RD,
    S_DN_RD2,
    S_DN_CMP,
    S_TOP_RD,
    S_TOP_WAIT,
    S_OUT
  } state_e;

endpackage

### src/indexed_heap_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// indexed_heap_priority_queue_unit
// Binary heap priority queue with stable handles kept in on-chip memories.
// ----------------------------------------------------------------------------
// Run time per word depends on the operation: an insert climbs toward the root;
// a lookup, a full insert or a dead handle reads the top; a remove of the last
// entry skips the sift, else the last entry is moved up or down; the sift walk
// over the key/handle memory sets the time.
// Throughput: one word at a time; next word accepted once the unit is idle,
// a finished result waits in the output register. Reset clears size, free
// stack count and live bits at once.
module indexed_heap_priority_queue_unit
  import ihpq_pkg::*;
#(
  parameter int unsigned CAPACITY  = CapacityDef,
  parameter int unsigned KEY_WIDTH = KeyWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  // s_axis_tdata_i: opcode[1:0], key, handle, zero fill
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  input  logic [((OpW+KEY_WIDTH+HandleW+7)/8)*8-1:0] s_axis_tdata_i,
  // m_axis_tdata_o: status, new_handle, entry_key, entry_count, top_key,
  // top_handle, is_empty, zero fill
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  output logic [((StatusW+2*HandleW+2*KEY_WIDTH+$clog2(CAPACITY)+2+7)/8)*8-1:0]
               m_axis_tdata_o
);

  localparam int unsigned PW = $clog2(CAPACITY);
  localparam int unsigned CW = PW + 1;
  localparam int unsigned OutW = StatusW + HandleW + KEY_WIDTH + CW + KEY_WIDTH
                                 + HandleW + 1;
  localparam int unsigned OutPad = $bits(m_axis_tdata_o) - OutW;

  // memories
  logic [KEY_WIDTH-1:0] key_mem [CAPACITY];
  logic [HandleW-1:0]   hnd_mem [CAPACITY];
  logic [PW-1:0]        pos_mem [CAPACITY];
  logic [HandleW-1:0]   free_mem[CAPACITY];
  logic [CAPACITY-1:0]  live_q, live_d;

  logic hf_q;
  state_e state_q, state_d;
  logic [CW-1:0] size_q, size_d, fcnt_q, fcnt_d, fresh_q, fresh_d;
  op_e           op_q, op_d;
  logic [KEY_WIDTH-1:0] key_q, key_d, ekey_q, ekey_d, ck_q, ck_d;
  logic [KEY_WIDTH-1:0] bk_q, bk_d;
  logic [HandleW-1:0]   hin_q, hin_d, nh_q, nh_d, ch_q, ch_d;
  logic [HandleW-1:0]   bh_q, bh_d;
  logic [PW-1:0]        p_q, p_d, bp_q, bp_d;
  logic [CW-1:0]        cw_q, cw_d;
  logic [1:0]           st_q, st_d;
  logic [OutW-1:0]      res_q, res_d;
  logic                 ov_q, ov_d;

  // heap memories: one write port and one read port each
  logic kh_we, kh_re;
  logic [PW-1:0] kh_wa, kh_ra;
  logic [KEY_WIDTH-1:0] kh_wk, kh_rk;
  logic [HandleW-1:0]   kh_wh, kh_rh;
  logic pos_we, pos_re, fr_we, fr_re;
  logic [PW-1:0] pos_wa, pos_ra, pos_wd, pos_rd, fr_wa, fr_ra;
  logic [HandleW-1:0] fr_wd, fr_rd;

  always_ff @(posedge clk_i) begin
    if (kh_we) begin
      key_mem[kh_wa] <= kh_wk;
      hnd_mem[kh_wa] <= kh_wh;
    end
    if (kh_re) begin
      kh_rk <= key_mem[kh_ra];
      kh_rh <= hnd_mem[kh_ra];
    end
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    if (pos_re) pos_rd <= pos_mem[pos_ra];
    if (fr_we) free_mem[fr_wa] <= fr_wd;
    if (fr_re) fr_rd <= free_mem[fr_ra];
  end

  function automatic logic above(input logic hf, input logic [KEY_WIDTH-1:0] a,
                                 input logic [KEY_WIDTH-1:0] b);
    above = hf ? (a > b) : (a < b);
  endfunction

  logic in_fire, out_fire;
  logic [OpW-1:0]       in_op;
  logic [KEY_WIDTH-1:0] in_key;
  logic [HandleW-1:0]   in_hnd;
  logic [PW-1:0]        par, lft;
  logic [CW-1:0]        lft_w, rgt_w;

  assign in_op  = s_axis_tdata_i[OpW-1:0];
  assign in_key = s_axis_tdata_i[OpW+KEY_WIDTH-1:OpW];
  assign in_hnd = s_axis_tdata_i[OpW+KEY_WIDTH+HandleW-1:OpW+KEY_WIDTH];
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = ov_q;
  assign out_fire = ov_q && m_axis_tready_i;
  assign m_axis_tdata_o  = {{OutPad{1'b0}}, res_q};
  assign par   = PW'((p_q - PW'(1)) >> 1);
  assign lft_w = {p_q, 1'b1};
  assign rgt_w = lft_w + CW'(1);
  assign lft   = lft_w[PW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hf_q <= 1'b1;
      state_q <= S_IDLE;
      size_q <= '0;
      fcnt_q <= '0;
      fresh_q <= '0;
      live_q <= '0;
      ov_q <= 1'b0;
    end else begin
      if (cfg_we_i) hf_q <= cfg_wdata_i;
      state_q <= state_d;
      size_q <= size_d;
      fcnt_q <= fcnt_d;
      fresh_q <= fresh_d;
      live_q <= live_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; key_q <= key_d; ekey_q <= ekey_d; ck_q <= ck_d;
    bk_q <= bk_d; hin_q <= hin_d; nh_q <= nh_d; ch_q <= ch_d;
    bh_q <= bh_d; p_q <= p_d; bp_q <= bp_d; cw_q <= cw_d; st_q <= st_d;
    res_q <= res_d;
  end

  always_comb begin
    state_d = state_q; size_d = size_q; fcnt_d = fcnt_q; fresh_d = fresh_q;
    live_d = live_q; ov_d = ov_q && !out_fire;
    op_d = op_q; key_d = key_q; ekey_d = ekey_q; ck_d = ck_q;
    bk_d = bk_q; hin_d = hin_q; nh_d = nh_q; ch_d = ch_q;
    bh_d = bh_q; p_d = p_q; bp_d = bp_q; cw_d = cw_q; st_d = st_q;
    res_d = res_q;
    kh_we = 1'b0; kh_re = 1'b0; kh_wa = p_q; kh_ra = p_q; kh_wk = ck_q;
    kh_wh = ch_q; pos_we = 1'b0; pos_re = 1'b0; pos_wa = ch_q[PW-1:0];
    pos_ra = in_hnd[PW-1:0]; pos_wd = p_q; fr_we = 1'b0; fr_re = 1'b0;
    fr_wa = fcnt_q[PW-1:0]; fr_ra = PW'(fcnt_q - CW'(1)); fr_wd = hin_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d = op_e'(in_op); key_d = in_key; hin_d = in_hnd;
          st_d = ST_OK; nh_d = '0; ekey_d = '0;
          unique case (op_e'(in_op))
            OP_INSERT: begin
              if (size_q == CW'(CAPACITY)) begin
                st_d = ST_FULL; state_d = S_TOP_RD;
              end else begin
                fr_re = 1'b1; state_d = S_INS_RD;
              end
            end
            OP_REMOVE, OP_LOOKUP: begin
              if ({1'b0, in_hnd} >= (HandleW+1)'(CAPACITY) ||
                  !live_q[in_hnd[PW-1:0]]) begin
                st_d = ST_DEAD; state_d = S_TOP_RD;
              end else begin
                pos_re = 1'b1; state_d = S_RM_RD;
              end
            end
            default: state_d = S_TOP_RD;
          endcase
        end
      end
      S_INS_RD: begin
        if (fcnt_q != '0) begin
          ch_d = HandleW'(fr_rd[PW-1:0]); fcnt_d = fcnt_q - CW'(1);
        end else begin
          ch_d = HandleW'(fresh_q[PW-1:0]); fresh_d = fresh_q + CW'(1);
        end
        ck_d = key_q; p_d = size_q[PW-1:0];
        state_d = S_INS_WR;
      end
      S_INS_WR: begin
        nh_d = ch_q; live_d[ch_q[PW-1:0]] = 1'b1; size_d = size_q + CW'(1);
        kh_we = 1'b1; pos_we = 1'b1;
        state_d = S_UP_RD;
      end
      // carried entry (ck,ch) sits at p; compare with parent
      S_UP_RD: begin
        if (p_q == '0) begin
          state_d = (op_q == OP_REMOVE) ? S_DN_RD : S_TOP_RD;
        end else begin
          kh_re = 1'b1; kh_ra = par; state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (above(hf_q, ck_q, kh_rk)) begin
          kh_we = 1'b1; kh_wa = p_q; kh_wk = kh_rk; kh_wh = kh_rh;
          pos_we = 1'b1; pos_wa = kh_rh[PW-1:0]; pos_wd = p_q;
          p_d = par; state_d = S_INS_WR;
          // rewrite carried entry at parent, then continue
          state_d = S_RM_WR;
        end else begin
          state_d = (op_q == OP_REMOVE) ? S_DN_RD : S_TOP_RD;
        end
      end
      S_RM_WR: begin
        kh_we = 1'b1; pos_we = 1'b1; state_d = S_UP_RD;
      end
      S_RM_RD: begin
        p_d = pos_rd; kh_re = 1'b1; kh_ra = pos_rd; state_d = S_RM_LAST;
      end
      S_RM_LAST: begin
        ekey_d = kh_rk;
        if (op_q == OP_LOOKUP) begin
          state_d = S_TOP_RD;
        end else begin
          live_d[hin_q[PW-1:0]] = 1'b0;
          size_d = size_q - CW'(1);
          if (fcnt_q < CW'(CAPACITY)) begin
            fr_we = 1'b1; fcnt_d = fcnt_q + CW'(1);
          end
          if ({1'b0, p_q} == size_q - CW'(1)) begin
            state_d = S_TOP_RD;
          end else begin
            kh_re = 1'b1; kh_ra = PW'(size_q - CW'(1)); state_d = S_DN_RD2;
            cw_d = '1;
          end
        end
      end
      S_DN_RD: begin
        // sift down: read left child
        if (lft_w >= size_q) begin
          state_d = S_TOP_RD;
        end else begin
          kh_re = 1'b1; kh_ra = lft; cw_d = '0; state_d = S_DN_RD2;
        end
      end
      S_DN_RD2: begin
        if (cw_q == '1) begin
          // last entry loaded: place it in the freed slot, then sift up
          ck_d = kh_rk; ch_d = kh_rh; state_d = S_RM_WR;
        end else if (cw_q == '0) begin
          bk_d = kh_rk; bh_d = kh_rh; bp_d = lft;
          if (rgt_w < size_q) begin
            kh_re = 1'b1; kh_ra = rgt_w[PW-1:0]; cw_d = CW'(1);
            state_d = S_DN_RD2;
          end else begin
            state_d = S_DN_CMP;
          end
        end else begin
          if (above(hf_q, kh_rk, bk_q)) begin
            bk_d = kh_rk; bh_d = kh_rh; bp_d = rgt_w[PW-1:0];
          end
          state_d = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (above(hf_q, bk_q, ck_q)) begin
          kh_we = 1'b1; kh_wa = p_q; kh_wk = bk_q; kh_wh = bh_q;
          pos_we = 1'b1; pos_wa = bh_q[PW-1:0]; pos_wd = p_q;
          p_d = bp_q; state_d = S_TOP_WAIT;
        end else begin
          state_d = S_TOP_RD;
        end
      end
      S_TOP_WAIT: begin
        kh_we = 1'b1; pos_we = 1'b1; state_d = S_DN_RD;
      end
      S_TOP_RD: begin
        kh_re = 1'b1; kh_ra = '0; state_d = S_OUT;
      end
      S_OUT: begin
        if (!ov_q || out_fire) begin
          res_d = {(size_q == '0),
                   (size_q == '0) ? '0 : kh_rh,
                   (size_q == '0) ? '0 : kh_rk,
                   size_q,
                   (st_q == ST_OK) ? ekey_q : '0,
                   nh_q, st_q};
          ov_d = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  property p_size_bound;
    @(posedge clk_i) disable iff (!rst_ni) size_q <= CW'(CAPACITY);
  endproperty
  a_size_bound: assert property (p_size_bound) else $error("heap size over capacity");

  property p_accept_idle;
    @(posedge clk_i) disable iff (!rst_ni) in_fire |=> (state_q != S_IDLE);
  endproperty
  a_accept_idle: assert property (p_accept_idle) else $error("word accepted without work");

  property p_fresh_bound;
    @(posedge clk_i) disable iff (!rst_ni) fcnt_q <= CW'(CAPACITY);
  endproperty
  a_fresh_bound: assert property (p_fresh_bound) else $error("free stack overflow");

endmodule
